/* sv/sha512bc_pkg.sv */
`default_nettype none
// ============================================================================
// SHA-512 block compressor package
// Shared types, round constants, initial hash values and the sigma functions.
// ============================================================================
package sha512bc_pkg;

  localparam int unsigned BlockWords  = 16;
  localparam int unsigned DigestWords = 8;
  localparam int unsigned RoundCount  = 80;

  typedef logic [DigestWords-1:0][63:0] hash_t;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StInit  = 5'b00010,
    StRound = 5'b00100,
    StFinal = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  typedef struct packed {
    logic       init;
    logic       step;
    logic [6:0] rnd;
  } round_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } sched_ctrl_t;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
    logic [127:0] dbl;
    dbl = {x, x};
    return dbl[n +: 64];
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
  endfunction

  function automatic logic [63:0] init_hash(input logic [2:0] i);
    logic [63:0] v;
    unique case (i)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      3'd7: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k;
    unique case (t)
      7'd0:  k = 64'h428a2f98d728ae22;
      7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;
      7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;
      7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;
      7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;
      7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;
      7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;
      7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;
      7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;
      7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;
      7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;
      7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;
      7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;
      7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;
      7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;
      7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;
      7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;
      7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;
      7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;
      7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;
      7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;
      7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;
      7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;
      7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;
      7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;
      7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;
      7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;
      7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;
      7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;
      7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;
      7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;
      7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;
      7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;
      7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;
      7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;
      7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;
      7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;
      7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;
      7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;
      7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* sv/sha512_block_compressor_core.sv */
`default_nettype none
// ============================================================================
// SHA-512 block compressor core
// Collects sixteen padded message words per block, runs the 80-round
// compression on one shared round unit and emits the digest after a final
// block.
// ============================================================================
// Words 1 to 15 of a block are collected while the core is idle.
// The sixteenth word starts the compression: a load step (StInit), the 80
// rounds of the single round unit (StRound) and a step that adds into the
// chaining words (StFinal). After a final block the eight digest words
// leave from StEmit at up to one per cycle, held while out_stall_i is set.
// Reset loads the standard initial hash values and clears the word position.
module sha512_block_compressor_core
  import sha512bc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] message_word_i,
  input  wire logic        start_message_i,
  input  wire logic        end_message_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [63:0] digest_word_o,
  output logic      [2:0]  word_index_o,
  output logic             last_word_o
);

  state_e      state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  pos;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        finish_q, finish_d;
  hash_t       hash_q, hash_d;
  hash_t       vars;
  logic        in_accept;
  logic        out_accept;
  logic [63:0] w0;
  logic [63:0] w1;
  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StEmit);
  assign out_accept  = out_valid_o && !out_stall_i;
  assign pos         = start_message_i ? 4'd0 : cnt_q;

  assign sched_ctrl.load = in_accept;
  assign sched_ctrl.step = (state_q == StRound);
  assign round_ctrl.init = (state_q == StInit);
  assign round_ctrl.step = (state_q == StRound);
  assign round_ctrl.rnd  = rnd_q;

  sha512bc_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_i (message_word_i),
    .w0_o   (w0),
    .w1_o   (w1)
  );

  sha512bc_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (round_ctrl),
    .hash_i (hash_q),
    .w0_i   (w0),
    .w1_i   (w1),
    .vars_o (vars)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rnd_d    = rnd_q;
    idx_d    = idx_q;
    finish_d = finish_q;
    hash_d   = hash_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (start_message_i) begin
            for (int i = 0; i < DigestWords; i++) begin
              hash_d[i] = init_hash(3'(i));
            end
          end
          if (pos == 4'(BlockWords - 1)) begin
            cnt_d    = 4'd0;
            finish_d = end_message_i;
            state_d  = StInit;
          end else begin
            cnt_d = 4'(pos + 4'd1);
          end
        end
      end
      StInit: begin
        rnd_d   = 7'd0;
        state_d = StRound;
      end
      StRound: begin
        rnd_d = 7'(rnd_q + 7'd1);
        if (rnd_q == 7'(RoundCount - 1)) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        for (int i = 0; i < DigestWords; i++) begin
          hash_d[i] = hash_q[i] + vars[i];
        end
        idx_d   = 3'd0;
        state_d = finish_q ? StEmit : StIdle;
      end
      StEmit: begin
        if (out_accept) begin
          idx_d = 3'(idx_q + 3'd1);
          if (idx_q == 3'(DigestWords - 1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= 4'd0;
      rnd_q    <= 7'd0;
      idx_q    <= 3'd0;
      finish_q <= 1'b0;
      for (int i = 0; i < DigestWords; i++) begin
        hash_q[i] <= init_hash(3'(i));
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      finish_q <= finish_d;
      hash_q   <= hash_d;
    end
  end

  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'(DigestWords - 1));

`ifndef SYNTH
  a_no_request_while_emitting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input request taken while digest words are pending");

  a_index_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && !last_word_o) |=>
      (out_valid_o && word_index_o == 3'($past(word_index_o) + 3'd1)))
    else $error("digest word index did not advance by one");

  a_block_end_starts_rounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && pos == 4'(BlockWords - 1)) |=> (state_q == StInit))
    else $error("sixteenth word did not start the compression");
`endif

endmodule
`default_nettype wire

/* sv/sha512bc_sched.sv */
`default_nettype none
// ============================================================================
// SHA-512 message schedule window
// Sixteen-word shift window that collects the block words and then expands
// one new schedule word per round.
// ============================================================================
module sha512bc_sched
  import sha512bc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire sched_ctrl_t ctrl_i,
  input  wire logic [63:0] word_i,
  output logic      [63:0] w0_o,
  output logic      [63:0] w1_o
);

  logic [63:0] win_q [BlockWords];
  logic [63:0] win_d [BlockWords];
  logic [63:0] expand_word;
  logic [63:0] in_word;

  assign expand_word = win_q[0] + small_sigma0(win_q[1]) + win_q[9]
                     + small_sigma1(win_q[14]);
  assign in_word     = ctrl_i.load ? word_i : expand_word;

  always_comb begin
    for (int i = 0; i < BlockWords - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[BlockWords-1] = in_word;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || ctrl_i.step) begin
      win_q <= win_d;
    end
  end

  assign w0_o = win_q[0];
  assign w1_o = win_q[1];

endmodule
`default_nettype wire

/* sv/sha512bc_round.sv */
`default_nettype none
// ============================================================================
// SHA-512 round unit
// Holds the eight working variables and applies one compression round per
// cycle while its step control is set. The sum of h, the round constant and
// the schedule word is registered a round ahead to shorten the adder chain.
// ============================================================================
module sha512bc_round
  import sha512bc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire round_ctrl_t ctrl_i,
  input  wire hash_t       hash_i,
  input  wire logic [63:0] w0_i,
  input  wire logic [63:0] w1_i,
  output hash_t            vars_o
);

  hash_t       vars_q;
  hash_t       vars_d;
  logic [63:0] hkw_q;
  logic [63:0] hkw_d;
  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] choose;
  logic [63:0] major;

  always_comb begin
    choose = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
    major  = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
    t1     = hkw_q + big_sigma1(vars_q[4]) + choose;
    t2     = big_sigma0(vars_q[0]) + major;
    vars_d    = vars_q;
    hkw_d     = hkw_q;
    if (ctrl_i.init) begin
      vars_d = hash_i;
      hkw_d  = hash_i[7] + round_k(7'd0) + w0_i;
    end else if (ctrl_i.step) begin
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
      hkw_d     = vars_q[6] + round_k(7'(ctrl_i.rnd + 7'd1)) + w1_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    hkw_q  <= hkw_d;
  end

  assign vars_o = vars_q;

endmodule
`default_nettype wire
